>>> design/json_keyed_object_extractor_core_assert.svh
// Assertion macros used by the extractor's parser module.
// Both expect signals named clk and rst_n in the scope where they are used.
`ifndef JSON_KEYED_OBJECT_EXTRACTOR_CORE_ASSERT_SVH
`define JSON_KEYED_OBJECT_EXTRACTOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JKOE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("jkoe: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define JKOE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("jkoe: next-cycle check failed");

`endif

>>> design/jkoe_pkg.sv
package jkoe_pkg;

  localparam int LEN_W = 15;
  localparam logic [LEN_W-1:0] LEN_MAX   = {LEN_W{1'b1}};
  localparam logic [LEN_W-1:0] CAP_RESET = 15'd8192;

  // The seven bytes that must precede the closing quote of the key.
  localparam logic [55:0] KEY_HEAD = 56'h22_72_65_70_6F_72_74;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_OPEN  = 8'h7B;
  localparam logic [7:0] CH_CLOSE = 8'h7D;
  localparam logic [7:0] CH_BSL   = 8'h5C;

  localparam logic [1:0] ST_BYTE = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_FAIL = 2'd2;
  localparam logic [1:0] ST_BIG  = 2'd3;

  typedef enum logic [4:0] {
    PH_KEY    = 5'b00001,
    PH_COLON  = 5'b00010,
    PH_BRACE  = 5'b00100,
    PH_OBJECT = 5'b01000,
    PH_DONE   = 5'b10000
  } phase_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       eor;
  } item_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic [1:0] status;
    logic       last;
  } result_t;

endpackage

>>> design/jkoe_in_if.sv
interface jkoe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_response;

  modport source(output valid, output in_byte, output end_of_response, input ready);
  modport sink(input valid, input in_byte, input end_of_response, output ready);
endinterface

>>> design/jkoe_out_if.sv
interface jkoe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] status;
  logic       last;

  modport source(output valid, output out_byte, output status, output last, input ready);
  modport sink(input valid, input out_byte, input status, input last, output ready);
endinterface

>>> design/jkoe_cfg_if.sv
interface jkoe_cfg_if;
  logic        valid;
  logic        ready;
  logic [14:0] capacity;

  modport source(output valid, output capacity, input ready);
  modport sink(input valid, input capacity, output ready);
endinterface

>>> design/json_keyed_object_extractor_core.sv
// Extracts the JSON object stored under the key "report" from a byte stream.
// in_if carries one beat per response byte, or an end-of-response beat that
// rearms the block for the next response. out_if carries the object's bytes
// with status 0, then one final beat with last set: status 1 with the closing
// brace, 2 when the key or object was not found or was cut short, 3 when the
// object length reached the capacity (out_byte is 0 on both failures).
// cfg_if writes the capacity; it is always ready and should be written only
// while no beat is in flight.
// Each beat passes an input register and an output register. A result is
// presented on out_if once its input beat has moved from the input register
// into the output register, which can wait while the receiver stalls.
// The parser handles one byte per cycle, giving one beat per cycle sustained
// throughput while the receiver keeps up.
// Reset sets the capacity to 8192 and starts searching for the key; no
// clearing pass is needed. When the receiver stalls, the output register
// holds its beat and an empty input register still takes one more beat
// before in_if.ready drops.
module json_keyed_object_extractor_core #(
  parameter int MAX_NESTING = 4095
) (
  input logic        clk,
  input logic        rst_n,
  jkoe_in_if.sink    in_if,
  jkoe_out_if.source out_if,
  jkoe_cfg_if.sink   cfg_if
);

  jkoe_pkg::item_t   item;
  jkoe_pkg::result_t res;
  logic              proceed;
  logic              fire;

  assign fire = item.valid && proceed;

  jkoe_in_stage u_in_stage (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .take  (fire),
    .item  (item)
  );

  jkoe_parser #(
    .MAX_NESTING (MAX_NESTING)
  ) u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .item   (item),
    .fire   (fire),
    .cfg_if (cfg_if),
    .res    (res)
  );

  jkoe_out_stage u_out_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .res     (res),
    .proceed (proceed),
    .out_if  (out_if)
  );

endmodule

>>> design/jkoe_in_stage.sv
module jkoe_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  jkoe_in_if.sink        in_if,
  input  logic           take,
  output jkoe_pkg::item_t item
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] data_r;
  logic       eor_r;
  logic       accept;

  // The register may refill in the same cycle that the parser drains it.
  assign in_if.ready = !valid_r || take;
  assign accept      = in_if.valid && in_if.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_r <= in_if.in_byte;
      eor_r  <= in_if.end_of_response;
    end
  end

  assign item.valid = valid_r;
  assign item.data  = data_r;
  assign item.eor   = eor_r;

endmodule

>>> design/jkoe_parser.sv
`include "json_keyed_object_extractor_core_assert.svh"

module jkoe_parser #(
  parameter int MAX_NESTING = 4095
) (
  input  logic             clk,
  input  logic             rst_n,
  input  jkoe_pkg::item_t  item,
  input  logic             fire,
  jkoe_cfg_if.sink         cfg_if,
  output jkoe_pkg::result_t res
);

  localparam int NEST_W = $clog2(MAX_NESTING + 1);
  localparam logic [NEST_W-1:0] NEST_MAX = NEST_W'(MAX_NESTING);

  jkoe_pkg::phase_t phase_r, phase_nxt;
  logic [55:0]                 recent_r, recent_nxt;
  logic [NEST_W-1:0]           nest_r, nest_nxt;
  logic                        str_r, str_nxt;
  logic                        bs_r, bs_nxt;
  logic [jkoe_pkg::LEN_W-1:0]  len_r, len_nxt;
  logic [jkoe_pkg::LEN_W-1:0]  cap_r;

  // Object state as seen by the current byte: an opening brace found in the
  // brace search starts from a clean slate.
  logic [NEST_W-1:0]           nest_cur;
  logic [NEST_W-1:0]           nest_dec;
  logic                        str_cur;
  logic                        bs_cur;
  logic [jkoe_pkg::LEN_W-1:0]  len_cur;
  logic                        in_obj;
  logic [7:0]                  b;

  assign cfg_if.ready = 1'b1;
  assign b            = item.data;

  always_comb begin
    if (phase_r == jkoe_pkg::PH_BRACE) begin
      nest_cur = '0;
      str_cur  = 1'b0;
      bs_cur   = 1'b0;
      len_cur  = '0;
    end else begin
      nest_cur = nest_r;
      str_cur  = str_r;
      bs_cur   = bs_r;
      len_cur  = len_r;
    end
  end

  assign nest_dec = (nest_cur != '0) ? nest_cur - NEST_W'(1) : nest_cur;

  always_comb begin
    phase_nxt  = phase_r;
    recent_nxt = recent_r;
    nest_nxt   = nest_r;
    str_nxt    = str_r;
    bs_nxt     = bs_r;
    len_nxt    = len_r;
    in_obj     = 1'b0;
    res        = '0;
    if (fire) begin
      if (item.eor) begin
        phase_nxt  = jkoe_pkg::PH_KEY;
        recent_nxt = '0;
        nest_nxt   = '0;
        str_nxt    = 1'b0;
        bs_nxt     = 1'b0;
        len_nxt    = '0;
        if (phase_r != jkoe_pkg::PH_DONE) begin
          res.valid  = 1'b1;
          res.status = jkoe_pkg::ST_FAIL;
          res.last   = 1'b1;
        end
      end else if (phase_r != jkoe_pkg::PH_DONE) begin
        if (b == jkoe_pkg::CH_NUL) begin
          phase_nxt  = jkoe_pkg::PH_DONE;
          res.valid  = 1'b1;
          res.status = jkoe_pkg::ST_FAIL;
          res.last   = 1'b1;
        end else begin
          unique case (phase_r)
            jkoe_pkg::PH_KEY: begin
              if (recent_r == jkoe_pkg::KEY_HEAD && b == jkoe_pkg::CH_QUOTE) begin
                phase_nxt = jkoe_pkg::PH_COLON;
              end
              recent_nxt = {recent_r[47:0], b};
            end
            jkoe_pkg::PH_COLON: begin
              if (b == jkoe_pkg::CH_COLON) begin
                phase_nxt = jkoe_pkg::PH_BRACE;
              end
            end
            jkoe_pkg::PH_BRACE: begin
              if (b == jkoe_pkg::CH_OPEN) begin
                phase_nxt = jkoe_pkg::PH_OBJECT;
                in_obj    = 1'b1;
              end
            end
            jkoe_pkg::PH_OBJECT: begin
              in_obj = 1'b1;
            end
            jkoe_pkg::PH_DONE: begin
            end
            default: begin
            end
          endcase
        end
      end
    end

    if (in_obj) begin
      len_nxt    = (len_cur != jkoe_pkg::LEN_MAX) ? len_cur + jkoe_pkg::LEN_W'(1) : len_cur;
      nest_nxt   = nest_cur;
      str_nxt    = str_cur;
      bs_nxt     = bs_cur;
      res.valid  = 1'b1;
      res.data   = b;
      res.status = jkoe_pkg::ST_BYTE;
      res.last   = 1'b0;
      if (str_cur) begin
        if (bs_cur) begin
          bs_nxt = 1'b0;
        end else if (b == jkoe_pkg::CH_BSL) begin
          bs_nxt = 1'b1;
        end else if (b == jkoe_pkg::CH_QUOTE) begin
          str_nxt = 1'b0;
        end
      end else if (b == jkoe_pkg::CH_QUOTE) begin
        str_nxt = 1'b1;
      end else if (b == jkoe_pkg::CH_OPEN) begin
        if (nest_cur < NEST_MAX) begin
          nest_nxt = nest_cur + NEST_W'(1);
        end
      end else if (b == jkoe_pkg::CH_CLOSE) begin
        nest_nxt = nest_dec;
        if (nest_dec == '0) begin
          phase_nxt = jkoe_pkg::PH_DONE;
          res.last  = 1'b1;
          // The length already counts this closing brace.
          if (len_nxt >= cap_r) begin
            res.data   = jkoe_pkg::CH_NUL;
            res.status = jkoe_pkg::ST_BIG;
          end else begin
            res.status = jkoe_pkg::ST_DONE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= jkoe_pkg::PH_KEY;
      recent_r <= '0;
      nest_r   <= '0;
      str_r    <= 1'b0;
      bs_r     <= 1'b0;
      len_r    <= '0;
      cap_r    <= jkoe_pkg::CAP_RESET;
    end else begin
      phase_r  <= phase_nxt;
      recent_r <= recent_nxt;
      nest_r   <= nest_nxt;
      str_r    <= str_nxt;
      bs_r     <= bs_nxt;
      len_r    <= len_nxt;
      if (cfg_if.valid && cfg_if.ready) begin
        cap_r <= cfg_if.capacity;
      end
    end
  end

  `JKOE_ASSERT_NOW(a_quiet_when_done, fire && !item.eor && phase_r == jkoe_pkg::PH_DONE, !res.valid)
  `JKOE_ASSERT_NEXT(a_rearm_clears, fire && item.eor, phase_r == jkoe_pkg::PH_KEY && nest_r == '0 && len_r == '0 && !str_r)
  `JKOE_ASSERT_NOW(a_complete_is_brace, res.valid && res.status == jkoe_pkg::ST_DONE, res.data == jkoe_pkg::CH_CLOSE && res.last)
  `JKOE_ASSERT_NOW(a_depth_only_in_object, nest_r != '0 || str_r || bs_r, phase_r == jkoe_pkg::PH_OBJECT || phase_r == jkoe_pkg::PH_DONE)

endmodule

>>> design/jkoe_out_stage.sv
module jkoe_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  jkoe_pkg::result_t res,
  output logic              proceed,
  jkoe_out_if.source        out_if
);

  logic       valid_r;
  logic [7:0] data_r;
  logic [1:0] status_r;
  logic       last_r;

  // The register takes a new result whenever it is empty or being drained.
  assign proceed = !valid_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (proceed) begin
      valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (proceed && res.valid) begin
      data_r   <= res.data;
      status_r <= res.status;
      last_r   <= res.last;
    end
  end

  assign out_if.valid    = valid_r;
  assign out_if.out_byte = data_r;
  assign out_if.status   = status_r;
  assign out_if.last     = last_r;

endmodule

>>> tb/sv/tb_json_keyed_object_extractor_core.sv
module tb_json_keyed_object_extractor_core;

  localparam int NEST_MAX     = 4095;
  localparam int SETTLE       = 8;
  localparam int DRAIN        = 12;
  localparam int RANDOM_BEATS = 500;
  localparam int CYCLE_LIMIT  = 100000;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] status;
    logic       last;
  } obj_beat_t;

  typedef logic [7:0] text_t[$];

  typedef enum int {
    RESP_GOOD,
    RESP_TRUNC,
    RESP_NUL,
    RESP_NOKEY,
    RESP_NOISE
  } resp_kind_t;

  // Tracks the extractor state and holds the result beats still owed by the block.
  class extract_scoreboard;
    logic [14:0]      capacity;
    jkoe_pkg::phase_t phase;
    logic [55:0]      recent;
    logic [11:0]      nesting;
    logic             in_str;
    logic             escaped;
    logic [14:0]      obj_len;
    obj_beat_t        owed[$];
    int               errors;
    int               results;
    int               completes;
    int               fails;
    int               bigs;

    function new();
      capacity = jkoe_pkg::CAP_RESET;
      errors = 0;
      results = 0;
      completes = 0;
      fails = 0;
      bigs = 0;
      rearm();
    endfunction

    function void rearm();
      phase = jkoe_pkg::PH_KEY;
      recent = '0;
      nesting = '0;
      in_str = 1'b0;
      escaped = 1'b0;
      obj_len = '0;
    endfunction

    function void set_capacity(logic [14:0] c);
      capacity = c;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    function void owe(logic [7:0] b, logic [1:0] s, logic l);
      obj_beat_t r;
      r.data = b;
      r.status = s;
      r.last = l;
      owed.push_back(r);
    endfunction

    function void note_input(logic [7:0] b, logic e);
      if (e) begin
        if (phase != jkoe_pkg::PH_DONE) owe(jkoe_pkg::CH_NUL, jkoe_pkg::ST_FAIL, 1'b1);
        rearm();
        return;
      end
      if (phase == jkoe_pkg::PH_DONE) return;
      if (b == jkoe_pkg::CH_NUL) begin
        phase = jkoe_pkg::PH_DONE;
        owe(jkoe_pkg::CH_NUL, jkoe_pkg::ST_FAIL, 1'b1);
        return;
      end
      case (phase)
        jkoe_pkg::PH_KEY: begin
          if (recent == jkoe_pkg::KEY_HEAD && b == jkoe_pkg::CH_QUOTE) begin
            phase = jkoe_pkg::PH_COLON;
          end
          recent = {recent[47:0], b};
          return;
        end
        jkoe_pkg::PH_COLON: begin
          if (b == jkoe_pkg::CH_COLON) phase = jkoe_pkg::PH_BRACE;
          return;
        end
        jkoe_pkg::PH_BRACE: begin
          if (b != jkoe_pkg::CH_OPEN) return;
          phase = jkoe_pkg::PH_OBJECT;
          nesting = '0;
          in_str = 1'b0;
          escaped = 1'b0;
          obj_len = '0;
        end
        default: ;
      endcase

      if (obj_len != jkoe_pkg::LEN_MAX) obj_len++;
      if (in_str) begin
        if (escaped) escaped = 1'b0;
        else if (b == jkoe_pkg::CH_BSL) escaped = 1'b1;
        else if (b == jkoe_pkg::CH_QUOTE) in_str = 1'b0;
      end else if (b == jkoe_pkg::CH_QUOTE) begin
        in_str = 1'b1;
      end else if (b == jkoe_pkg::CH_OPEN) begin
        if (nesting < NEST_MAX) nesting++;
      end else if (b == jkoe_pkg::CH_CLOSE) begin
        if (nesting != 0) nesting--;
        if (nesting == 0) begin
          phase = jkoe_pkg::PH_DONE;
          if (obj_len >= capacity) owe(jkoe_pkg::CH_NUL, jkoe_pkg::ST_BIG, 1'b1);
          else owe(b, jkoe_pkg::ST_DONE, 1'b1);
          return;
        end
      end
      owe(b, jkoe_pkg::ST_BYTE, 1'b0);
    endfunction

    function void check_result(logic [7:0] b, logic [1:0] s, logic l);
      obj_beat_t want;
      results++;
      case (s)
        jkoe_pkg::ST_DONE: completes++;
        jkoe_pkg::ST_FAIL: fails++;
        jkoe_pkg::ST_BIG:  bigs++;
        default: ;
      endcase
      if (owed.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %02h/%0d/%0d",
                 $time, b, s, l);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (b !== want.data) begin
        $display("%0t: out_byte mismatch, expected %02h actual %02h", $time, want.data, b);
        errors++;
      end
      if (s !== want.status) begin
        $display("%0t: status mismatch, expected %0d actual %0d", $time, want.status, s);
        errors++;
      end
      if (l !== want.last) begin
        $display("%0t: last mismatch, expected %0d actual %0d", $time, want.last, l);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  jkoe_in_if  in_if();
  jkoe_out_if out_if();
  jkoe_cfg_if cfg_if();

  json_keyed_object_extractor_core #(
    .MAX_NESTING(NEST_MAX)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .out_if(out_if),
    .cfg_if(cfg_if)
  );

  extract_scoreboard sb = new();

  int cycle_count = 0;
  int burst_left  = 0;
  int beats_sent  = 0;
  int responses   = 0;
  int cap_writes  = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[json_keyed_object_extractor_core] ERROR");
      $finish;
    end
  end

  // Both channels are sampled here, with the values that held before the edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid === 1'b1 && in_if.ready === 1'b1)
        sb.note_input(in_if.in_byte, in_if.end_of_response);
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1)
        sb.check_result(out_if.out_byte, out_if.status, out_if.last);
    end
  end

  // The receiver cycles through free running, random stalls and periodic stalls.
  initial begin
    int mode;
    int len;
    int per;
    out_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      mode = $urandom_range(0, 3);
      len = $urandom_range(20, 200);
      per = $urandom_range(2, 8);
      for (int i = 0; i < len; i++) begin
        @(posedge clk);
        case (mode)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= ($urandom_range(0, 3) != 0);
          2: out_if.ready <= ((i % per) < (per / 2));
          default: out_if.ready <= ((i % 7) == 6);
        endcase
      end
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic e);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      if ($urandom_range(0, 4) == 0) burst_left = $urandom_range(100, 200);
      else burst_left = $urandom_range(1, 24);
    end
    in_if.valid <= 1'b1;
    in_if.in_byte <= b;
    in_if.end_of_response <= e;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    if (burst_left > 0) burst_left--;
    beats_sent++;
  endtask

  task automatic send_text(input text_t q, input bit with_eor);
    foreach (q[i]) send_beat(q[i], 1'b0);
    if (with_eor) send_beat(8'($urandom_range(0, 255)), 1'b1);
    responses++;
  endtask

  // All beats must drain before a new capacity; the block does not enforce this.
  task automatic write_capacity(input logic [14:0] c);
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.capacity <= c;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    cfg_if.valid <= 1'b0;
    sb.set_capacity(c);
    cap_writes++;
  endtask

  function automatic void add_str(ref text_t q, input string s);
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
  endfunction

  function automatic logic [7:0] pick_char(input bit high, input logic [7:0] skip);
    logic [7:0] c;
    do begin
      if (high) c = 8'($urandom_range(1, 255));
      else c = 8'($urandom_range(32, 126));
    end while (c == skip);
    return c;
  endfunction

  function automatic void add_noise(ref text_t q, input int n, input logic [7:0] skip);
    bit high;
    high = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++) q.push_back(pick_char(high, skip));
  endfunction

  function automatic void add_string(ref text_t q);
    int n;
    logic [7:0] c;
    n = $urandom_range(0, 6);
    q.push_back(jkoe_pkg::CH_QUOTE);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 5))
        0: begin
          q.push_back(jkoe_pkg::CH_BSL);
          case ($urandom_range(0, 3))
            0: q.push_back(jkoe_pkg::CH_QUOTE);
            1: q.push_back(jkoe_pkg::CH_BSL);
            2: q.push_back(jkoe_pkg::CH_CLOSE);
            default: q.push_back(pick_char(1'b1, jkoe_pkg::CH_NUL));
          endcase
        end
        1: q.push_back(jkoe_pkg::CH_OPEN);
        2: q.push_back(jkoe_pkg::CH_CLOSE);
        default: begin
          do c = pick_char($urandom_range(0, 4) == 0, jkoe_pkg::CH_QUOTE);
          while (c == jkoe_pkg::CH_BSL);
          q.push_back(c);
        end
      endcase
    end
    q.push_back(jkoe_pkg::CH_QUOTE);
  endfunction

  function automatic void add_object(ref text_t q, input int depth);
    int members;
    members = $urandom_range(0, 3);
    q.push_back(jkoe_pkg::CH_OPEN);
    for (int m = 0; m < members; m++) begin
      if (m != 0) q.push_back(8'h2C);
      add_string(q);
      q.push_back(jkoe_pkg::CH_COLON);
      case ($urandom_range(0, 4))
        0: add_str(q, "42");
        1: add_string(q);
        2: begin
          // A backslash outside a string is just another byte.
          q.push_back(jkoe_pkg::CH_BSL);
          add_str(q, "7");
        end
        default: begin
          if (depth < 3) add_object(q, depth + 1);
          else add_str(q, "true");
        end
      endcase
    end
    q.push_back(jkoe_pkg::CH_CLOSE);
  endfunction

  task automatic send_response();
    text_t q;
    resp_kind_t kind;
    int start;
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 11) kind = RESP_GOOD;
    else if (pick < 14) kind = RESP_TRUNC;
    else if (pick < 16) kind = RESP_NUL;
    else if (pick < 18) kind = RESP_NOKEY;
    else kind = RESP_NOISE;

    if ($urandom_range(0, 3) == 0) add_str(q, "{\"repor\":1,\"reporT\"");
    add_noise(q, $urandom_range(0, 5), jkoe_pkg::CH_NUL);
    if (kind == RESP_NOKEY) begin
      add_str(q, "\"report");
      add_noise(q, $urandom_range(0, 4), jkoe_pkg::CH_QUOTE);
    end else if (kind == RESP_NOISE) begin
      if ($urandom_range(0, 1) == 0) add_str(q, "\"report\"");
      add_noise(q, $urandom_range(4, 20), jkoe_pkg::CH_NUL);
    end else begin
      add_str(q, "\"report\"");
      add_noise(q, $urandom_range(0, 3), jkoe_pkg::CH_COLON);
      q.push_back(jkoe_pkg::CH_COLON);
      add_noise(q, $urandom_range(0, 3), jkoe_pkg::CH_OPEN);
      start = q.size();
      add_object(q, 0);
      add_noise(q, $urandom_range(0, 4), jkoe_pkg::CH_NUL);
      if ($urandom_range(0, 3) == 0) q.push_back(jkoe_pkg::CH_NUL);
      if (kind == RESP_TRUNC) begin
        pick = $urandom_range(start + 1, q.size() - 1);
        while (q.size() > pick) void'(q.pop_back());
      end else if (kind == RESP_NUL) begin
        q.insert($urandom_range(0, q.size() - 1), jkoe_pkg::CH_NUL);
      end
    end
    send_text(q, $urandom_range(0, 19) != 0);
  endtask

  initial begin
    text_t q;
    int base;
    logic [14:0] cap;

    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.in_byte <= '0;
    in_if.end_of_response <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.capacity <= jkoe_pkg::CAP_RESET;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: end of response while seeking, zero byte, ignored bytes once
    // finished, a stray backslash in the object, and a capacity of zero.
    send_beat(8'hA5, 1'b1);
    send_beat(jkoe_pkg::CH_NUL, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h00, 1'b1);
    q = {};
    add_str(q, "\"report\":{\\}z");
    send_text(q, 1'b1);
    write_capacity(15'd0);
    q = {};
    add_str(q, "\"report\":{}");
    send_text(q, 1'b1);

    base = beats_sent;
    while (beats_sent - base < RANDOM_BEATS) begin
      case ($urandom_range(0, 9))
        0: cap = 15'd1;
        1: cap = 15'd16384;
        2: cap = jkoe_pkg::CAP_RESET;
        3: cap = jkoe_pkg::LEN_MAX;
        default: cap = 15'($urandom_range(2, 48));
      endcase
      write_capacity(cap);
      repeat ($urandom_range(2, 4)) send_response();
    end

    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("Sent %0d responses in %0d input beats over %0d capacity settings.",
             responses, beats_sent, cap_writes);
    $display("Checked %0d result beats: %0d complete, %0d failed, %0d too large.",
             sb.results, sb.completes, sb.fails, sb.bigs);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[json_keyed_object_extractor_core] OK");
    end else begin
      $display("[json_keyed_object_extractor_core] ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/jkoe_pkg.sv
design/jkoe_in_if.sv
design/jkoe_out_if.sv
design/jkoe_cfg_if.sv
design/jkoe_in_stage.sv
design/jkoe_parser.sv
design/jkoe_out_stage.sv
design/json_keyed_object_extractor_core.sv
tb/sv/tb_json_keyed_object_extractor_core.sv
